### hdl/fsps_pkg.sv
// ----------------------------------------------------------------------------
// fsps_pkg
// Shared types and constants for the four-sum two-pointer search core.
// ----------------------------------------------------------------------------
package fsps_pkg;

    localparam int MAX_ELEMS_DEF = 64;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_FETCH = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] first_value;
        logic signed [DATA_W-1:0] second_value;
        logic signed [DATA_W-1:0] third_value;
        logic signed [DATA_W-1:0] fourth_value;
        logic                     status;
        logic                     overflow;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LD0,
        S_LD1,
        S_O0,
        S_O1,
        S_O2,
        S_J0,
        S_J1,
        S_J2,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_L0,
        S_L1,
        S_H0,
        S_H1,
        S_EMIT_HIT,
        S_EMIT_MISS
    } state_t;

    typedef enum logic [2:0] {
        RD_OI_PREV,
        RD_OI,
        RD_IJ_PREV,
        RD_IJ,
        RD_LO,
        RD_HI,
        RD_P_PREV
    } rd_sel_t;

    typedef struct packed {
        rd_sel_t rd_sel;
        logic    clear;
        logic    load_accept;
        logic    wr_en;
        logic    wr_shift;
        logic    inc_count;
        logic    start_search;
        logic    ld_prev;
        logic    ld_vi;
        logic    ld_vj;
        logic    ld_vlo;
        logic    ld_vhi;
        logic    oi_next;
        logic    ij_inc;
        logic    pair_start;
        logic    pair_end;
        logic    lo_inc;
        logic    lo_dec;
        logic    hi_dec;
        logic    set_done;
        logic    emit_hit;
        logic    emit_miss;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic started;
        logic done;
        logic pair_active;
        logic oi_ge_n;
        logic oi_zero;
        logic ij_ge_n;
        logic ij_first;
        logic lo_lt_hi;
        logic p_zero;
        logic rd_eq_prev;
        logic rd_gt_value;
        logic rd_eq_vlo;
        logic rd_eq_vhi;
        logic sum_eq;
        logic sum_lt;
    } sts_t;

endpackage

### hdl/four_sum_two_pointer_search_core.sv
// ----------------------------------------------------------------------------
// four_sum_two_pointer_search_core
// Sorted store with a resumable exact four-sum search, one quadruple per fetch.
// ----------------------------------------------------------------------------
// Items are handled one at a time; in_stall is high while an item is at work.
// Every read of the sorted store goes through its single registered read
// port. A clear, an unused mode or a load into a full store is handled in
// the idle state without raising in_stall. A load walks down from the top
// of the store, reading each entry and shifting it up while it is greater
// than the new value, then writes the value into the gap. A fetch steps the
// outer and inner indices past repeated values, runs the two-pointer scan,
// skips repeats of the matched pair, and delivers its beat once the previous
// beat has drained, so its duration follows the data. target_sum is written
// through cfg_we/cfg_data while idle; the core itself does not enforce this.
// ----------------------------------------------------------------------------
module four_sum_two_pointer_search_core
    import fsps_pkg::*;
#(
    parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  in_item_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output out_item_t                out_data,
    input  logic                     cfg_we,
    input  logic signed [DATA_W-1:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    fsps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_mode   (in_data.mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    fsps_dp #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_value (in_data.value),
        .cmd      (cmd),
        .sts      (sts),
        .result   (out_data)
    );

endmodule

### hdl/fsps_ram.sv
// ----------------------------------------------------------------------------
// fsps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/fsps_ctrl.sv
// ----------------------------------------------------------------------------
// fsps_ctrl
// Sequencer for insertion and the resumable four-sum search.
// ----------------------------------------------------------------------------
module fsps_ctrl
    import fsps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] in_mode,
    output logic       out_valid,
    input  logic       out_stall,
    input  sts_t       sts,
    output cmd_t       cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.rd_sel     = RD_OI;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_mode)
                        MODE_CLEAR: cmd.clear = 1'b1;
                        MODE_LOAD:
                        begin
                            cmd.load_accept = 1'b1;
                            if (!sts.full)
                            begin
                                state_next = S_LD0;
                            end
                        end
                        MODE_FETCH:
                        begin
                            if (sts.done)
                            begin
                                state_next = S_EMIT_MISS;
                            end
                            else if (!sts.started)
                            begin
                                cmd.start_search = 1'b1;
                                state_next       = S_O0;
                            end
                            else
                            begin
                                state_next = sts.pair_active ? S_P0 : S_O0;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LD0:
            begin
                if (sts.p_zero)
                begin
                    cmd.wr_en     = 1'b1;
                    cmd.inc_count = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_P_PREV;
                    state_next = S_LD1;
                end
            end
            S_LD1:
            begin
                cmd.wr_en = 1'b1;
                if (sts.rd_gt_value)
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.lo_dec   = 1'b1;
                    state_next   = S_LD0;
                end
                else
                begin
                    cmd.inc_count = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_O0:
            begin
                if (sts.oi_ge_n)
                begin
                    cmd.set_done = 1'b1;
                    state_next   = S_EMIT_MISS;
                end
                else if (!sts.oi_zero)
                begin
                    cmd.rd_sel = RD_OI_PREV;
                    state_next = S_O1;
                end
                else
                begin
                    cmd.rd_sel = RD_OI;
                    state_next = S_O2;
                end
            end
            S_O1:
            begin
                cmd.ld_prev = 1'b1;
                cmd.rd_sel  = RD_OI;
                state_next  = S_O2;
            end
            S_O2:
            begin
                cmd.ld_vi = 1'b1;
                if (!sts.oi_zero && sts.rd_eq_prev)
                begin
                    cmd.oi_next = 1'b1;
                    state_next  = S_O0;
                end
                else
                begin
                    state_next = S_J0;
                end
            end
            S_J0:
            begin
                if (sts.ij_ge_n)
                begin
                    cmd.oi_next = 1'b1;
                    state_next  = S_O0;
                end
                else if (!sts.ij_first)
                begin
                    cmd.rd_sel = RD_IJ_PREV;
                    state_next = S_J1;
                end
                else
                begin
                    cmd.rd_sel = RD_IJ;
                    state_next = S_J2;
                end
            end
            S_J1:
            begin
                cmd.ld_prev = 1'b1;
                cmd.rd_sel  = RD_IJ;
                state_next  = S_J2;
            end
            S_J2:
            begin
                cmd.ld_vj = 1'b1;
                if (!sts.ij_first && sts.rd_eq_prev)
                begin
                    cmd.ij_inc = 1'b1;
                    state_next = S_J0;
                end
                else
                begin
                    cmd.pair_start = 1'b1;
                    state_next     = S_P0;
                end
            end
            S_P0:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.rd_sel = RD_LO;
                    state_next = S_P1;
                end
                else
                begin
                    cmd.pair_end = 1'b1;
                    state_next   = S_O0;
                end
            end
            S_P1:
            begin
                cmd.ld_vlo = 1'b1;
                cmd.rd_sel = RD_HI;
                state_next = S_P2;
            end
            S_P2:
            begin
                cmd.ld_vhi = 1'b1;
                state_next = S_P3;
            end
            S_P3:
            begin
                if (sts.sum_eq)
                begin
                    cmd.lo_inc = 1'b1;
                    cmd.hi_dec = 1'b1;
                    state_next = S_L0;
                end
                else if (sts.sum_lt)
                begin
                    cmd.lo_inc = 1'b1;
                    state_next = S_P0;
                end
                else
                begin
                    cmd.hi_dec = 1'b1;
                    state_next = S_P0;
                end
            end
            // skip repeats of the matched low value, then of the high value
            S_L0:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.rd_sel = RD_LO;
                    state_next = S_L1;
                end
                else
                begin
                    state_next = S_H0;
                end
            end
            S_L1:
            begin
                if (sts.rd_eq_vlo)
                begin
                    cmd.lo_inc = 1'b1;
                    state_next = S_L0;
                end
                else
                begin
                    state_next = S_H0;
                end
            end
            S_H0:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.rd_sel = RD_HI;
                    state_next = S_H1;
                end
                else
                begin
                    state_next = S_EMIT_HIT;
                end
            end
            S_H1:
            begin
                if (sts.rd_eq_vhi)
                begin
                    cmd.hi_dec = 1'b1;
                    state_next = S_H0;
                end
                else
                begin
                    state_next = S_EMIT_HIT;
                end
            end
            S_EMIT_HIT:
            begin
                if (slot_free)
                begin
                    cmd.emit_hit   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMIT_MISS:
            begin
                if (slot_free)
                begin
                    cmd.emit_miss  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

### hdl/fsps_dp.sv
// ----------------------------------------------------------------------------
// fsps_dp
// Datapath: sorted store, search indices, cached values, sum compare, result.
// ----------------------------------------------------------------------------
module fsps_dp
    import fsps_pkg::*;
#(
    parameter int MAX_ELEMS = MAX_ELEMS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic signed [DATA_W-1:0] cfg_data,
    input  logic signed [DATA_W-1:0] in_value,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    output out_item_t                result
);

    localparam int AW = $clog2(MAX_ELEMS);
    localparam int IW = $clog2(MAX_ELEMS + 2);

    logic [IW-1:0] count_reg, oi_reg, ij_reg, lo_reg, hi_reg;
    logic signed [DATA_W-1:0] target_reg, value_reg;
    logic signed [DATA_W-1:0] vprev_reg, vi_reg, vj_reg, vlo_reg, vhi_reg;
    logic signed [DATA_W:0]   pair_sum_reg, lh_sum_reg;
    logic started_reg, done_reg, pair_reg, ovf_reg;
    out_item_t result_reg;

    logic [IW-1:0]            raddr;
    logic [DATA_W-1:0]        rdata;
    logic signed [DATA_W-1:0] rd_s;
    logic signed [DATA_W+1:0] sum_full, tgt_full;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_OI_PREV: raddr = oi_reg - 1'b1;
            RD_OI:      raddr = oi_reg;
            RD_IJ_PREV: raddr = ij_reg - 1'b1;
            RD_IJ:      raddr = ij_reg;
            RD_LO:      raddr = lo_reg;
            RD_HI:      raddr = hi_reg;
            RD_P_PREV:  raddr = lo_reg - 1'b1;
            default:    raddr = oi_reg;
        endcase
    end

    fsps_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ELEMS)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (lo_reg[AW-1:0]),
        .wdata (cmd.wr_shift ? rdata : value_reg),
        .raddr (raddr[AW-1:0]),
        .rdata (rdata)
    );

    assign rd_s     = $signed(rdata);
    assign sum_full = (DATA_W+2)'(pair_sum_reg) + (DATA_W+2)'(lh_sum_reg);
    assign tgt_full = (DATA_W+2)'(target_reg);

    always_comb
    begin
        sts.full        = (count_reg == IW'(MAX_ELEMS));
        sts.started     = started_reg;
        sts.done        = done_reg;
        sts.pair_active = pair_reg;
        sts.oi_ge_n     = (oi_reg >= count_reg);
        sts.oi_zero     = (oi_reg == '0);
        sts.ij_ge_n     = (ij_reg >= count_reg);
        sts.ij_first    = (ij_reg == oi_reg + 1'b1);
        sts.lo_lt_hi    = (lo_reg < hi_reg);
        sts.p_zero      = (lo_reg == '0);
        sts.rd_eq_prev  = (rd_s == vprev_reg);
        sts.rd_gt_value = (rd_s > value_reg);
        sts.rd_eq_vlo   = (rd_s == vlo_reg);
        sts.rd_eq_vhi   = (rd_s == vhi_reg);
        sts.sum_eq      = (sum_full == tgt_full);
        sts.sum_lt      = (sum_full < tgt_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            oi_reg      <= '0;
            ij_reg      <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            target_reg  <= '0;
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            pair_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                target_reg <= cfg_data;
            end
            if (cmd.clear || cmd.load_accept)
            begin
                started_reg <= 1'b0;
                done_reg    <= 1'b0;
                pair_reg    <= 1'b0;
            end
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            if (cmd.load_accept)
            begin
                lo_reg <= count_reg;
                if (sts.full)
                begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.inc_count)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.start_search)
            begin
                oi_reg      <= '0;
                ij_reg      <= IW'(1);
                started_reg <= 1'b1;
            end
            if (cmd.oi_next)
            begin
                oi_reg <= oi_reg + 1'b1;
                ij_reg <= oi_reg + IW'(2);
            end
            if (cmd.ij_inc)
            begin
                ij_reg <= ij_reg + 1'b1;
            end
            if (cmd.pair_start)
            begin
                lo_reg   <= ij_reg + 1'b1;
                hi_reg   <= count_reg - 1'b1;
                pair_reg <= 1'b1;
            end
            if (cmd.pair_end)
            begin
                pair_reg <= 1'b0;
                ij_reg   <= ij_reg + 1'b1;
            end
            if (cmd.lo_inc)
            begin
                lo_reg <= lo_reg + 1'b1;
            end
            if (cmd.lo_dec)
            begin
                lo_reg <= lo_reg - 1'b1;
            end
            if (cmd.hi_dec)
            begin
                hi_reg <= hi_reg - 1'b1;
            end
            if (cmd.set_done)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_accept)
        begin
            value_reg <= in_value;
        end
        if (cmd.ld_prev)
        begin
            vprev_reg <= rd_s;
        end
        if (cmd.ld_vi)
        begin
            vi_reg <= rd_s;
        end
        if (cmd.ld_vj)
        begin
            vj_reg       <= rd_s;
            pair_sum_reg <= (DATA_W+1)'(vi_reg) + (DATA_W+1)'(rd_s);
        end
        if (cmd.ld_vlo)
        begin
            vlo_reg <= rd_s;
        end
        if (cmd.ld_vhi)
        begin
            vhi_reg    <= rd_s;
            lh_sum_reg <= (DATA_W+1)'(vlo_reg) + (DATA_W+1)'(rd_s);
        end
        if (cmd.emit_hit)
        begin
            result_reg.first_value  <= vi_reg;
            result_reg.second_value <= vj_reg;
            result_reg.third_value  <= vlo_reg;
            result_reg.fourth_value <= vhi_reg;
            result_reg.status       <= 1'b0;
            result_reg.overflow     <= ovf_reg;
        end
        if (cmd.emit_miss)
        begin
            result_reg.first_value  <= '0;
            result_reg.second_value <= '0;
            result_reg.third_value  <= '0;
            result_reg.fourth_value <= '0;
            result_reg.status       <= 1'b1;
            result_reg.overflow     <= ovf_reg;
        end
    end

    assign result = result_reg;

endmodule

### sim/four_sum_two_pointer_search_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_sum_two_pointer_search_core_test
// Self-checking bench: sorted loads, clears and resumable four-sum fetches.
// ----------------------------------------------------------------------------
// Beats are fed from a queue by a clocked driver with random gaps and drained
// by a clocked monitor with random stalls. A built-in predictor of the sorted
// store and the two-pointer search gives the expected result of each fetch.
// The target is rewritten between phases, once the core has gone quiet.
// ----------------------------------------------------------------------------
module four_sum_two_pointer_search_core_test;
    import fsps_pkg::*;

    localparam int STORE_DEPTH = 64;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    in_item_t                 in_data;
    logic                     out_valid;
    logic                     out_stall;
    out_item_t                out_data;
    logic                     cfg_we;
    logic signed [DATA_W-1:0] cfg_data;

    four_sum_two_pointer_search_core #(.MAX_ELEMS(STORE_DEPTH)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // predictor state
    logic signed [DATA_W-1:0] sorted_vals [STORE_DEPTH];
    int          elem_cnt;
    int          oi, ij, lo_p, hi_p;
    bit          started, exhausted, pair_on, ovf_flag;
    longint      target_q;

    in_item_t    pending_beats [$];
    out_item_t   quad_results [$];
    int          errors = 0;
    int          phase_no = 0;
    bit          calm = 0;
    bit          rx_hold = 0;
    int          tx_wait;
    int          rx_wait;

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    task automatic report(input string what);
        $display("[%0t] error: %s", $time, what);
        errors++;
    endtask

    function automatic void append_beat(input in_item_t it);
        pending_beats.insert(pending_beats.size(), it);
    endfunction

    function automatic void restart_search();
        oi = 0; ij = 0; lo_p = 0; hi_p = 0;
        started = 0; exhausted = 0; pair_on = 0;
    endfunction

    // next unique quadruple; fills quad and returns 1 on a hit
    function automatic bit next_quad(ref out_item_t quad);
        longint sum;
        bit     fin;
        bit     hit;
        int     lo, hi;
        fin = 0;
        hit = 0;
        if (!started)
        begin
            oi = 0; ij = 1; pair_on = 0; started = 1;
        end
        while (!fin)
        begin
            if (pair_on)
            begin
                while (!fin && lo_p < hi_p)
                begin
                    sum = longint'(sorted_vals[oi]) + longint'(sorted_vals[ij])
                        + longint'(sorted_vals[lo_p]) + longint'(sorted_vals[hi_p]);
                    if (sum == target_q)
                    begin
                        quad.first_value  = sorted_vals[oi];
                        quad.second_value = sorted_vals[ij];
                        quad.third_value  = sorted_vals[lo_p];
                        quad.fourth_value = sorted_vals[hi_p];
                        lo = lo_p + 1;
                        hi = hi_p - 1;
                        while (lo < hi && sorted_vals[lo] == sorted_vals[lo-1]) lo++;
                        while (lo < hi && sorted_vals[hi] == sorted_vals[hi+1]) hi--;
                        lo_p = lo;
                        hi_p = hi;
                        hit = 1;
                        fin = 1;
                    end
                    else if (sum < target_q)
                        lo_p++;
                    else
                        hi_p--;
                end
                if (!fin)
                begin
                    pair_on = 0;
                    ij++;
                end
            end
            if (!fin)
            begin
                if (oi >= elem_cnt)
                    fin = 1;
                else if (oi > 0 && sorted_vals[oi] == sorted_vals[oi-1])
                begin
                    oi++; ij = oi + 1;
                end
                else if (ij >= elem_cnt)
                begin
                    oi++; ij = oi + 1;
                end
                else if (ij != oi + 1 && sorted_vals[ij] == sorted_vals[ij-1])
                    ij++;
                else
                begin
                    lo_p = ij + 1; hi_p = elem_cnt - 1; pair_on = 1;
                end
            end
        end
        return hit;
    endfunction

    function automatic void predict_beat(input in_item_t it);
        out_item_t r;
        int        p;
        bit        hit;
        case (mode_t'(it.mode))
            MODE_CLEAR:
            begin
                elem_cnt = 0;
                restart_search();
            end
            MODE_LOAD:
            begin
                if (elem_cnt < STORE_DEPTH)
                begin
                    p = elem_cnt;
                    while (p > 0 && sorted_vals[p-1] > it.value)
                    begin
                        sorted_vals[p] = sorted_vals[p-1];
                        p--;
                    end
                    sorted_vals[p] = it.value;
                    elem_cnt++;
                end
                else
                    ovf_flag = 1;
                restart_search();
            end
            MODE_FETCH:
            begin
                r = '0;
                hit = 0;
                if (!exhausted)
                begin
                    hit = next_quad(r);
                    if (!hit)
                        exhausted = 1;
                end
                if (!hit)
                begin
                    r = '0;
                    r.status = 1'b1;
                end
                r.overflow = ovf_flag;
                quad_results.insert(quad_results.size(), r);
            end
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            tx_wait  <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                predict_beat(in_data);
            if (tx_wait > 0)
            begin
                tx_wait  <= tx_wait - 1;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                in_data  <= pending_beats.pop_front();
                in_valid <= 1'b1;
                tx_wait  <= calm ? 0 : $urandom_range(0, 4);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        int        nxt;
        out_item_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b1;
            rx_wait   <= 0;
        end
        else
        begin
            nxt = rx_wait;
            if (out_valid && !out_stall)
            begin
                if (quad_results.size() == 0)
                    report("result beat with nothing expected");
                else
                begin
                    want = quad_results.pop_front();
                    if (out_data.first_value !== want.first_value)
                        report($sformatf("first_value %0d, want %0d",
                            out_data.first_value, want.first_value));
                    if (out_data.second_value !== want.second_value)
                        report($sformatf("second_value %0d, want %0d",
                            out_data.second_value, want.second_value));
                    if (out_data.third_value !== want.third_value)
                        report($sformatf("third_value %0d, want %0d",
                            out_data.third_value, want.third_value));
                    if (out_data.fourth_value !== want.fourth_value)
                        report($sformatf("fourth_value %0d, want %0d",
                            out_data.fourth_value, want.fourth_value));
                    if (out_data.status !== want.status)
                        report($sformatf("status %b, want %b",
                            out_data.status, want.status));
                    if (out_data.overflow !== want.overflow)
                        report($sformatf("overflow %b, want %b",
                            out_data.overflow, want.overflow));
                end
                nxt = calm ? 0 : $urandom_range(0, 4);
            end
            else if (nxt > 0)
                nxt--;
            rx_wait   <= nxt;
            out_stall <= (nxt != 0) || rx_hold;
        end
    end

    // long receiver hold-off while fetches keep coming
    initial
    begin
        int n;
        wait (phase_no == 2);
        repeat (20) @(posedge clk);
        rx_hold <= 1'b1;
        for (n = 0; n < 400; n++)
            @(posedge clk);
        rx_hold <= 1'b0;
    end

    function automatic in_item_t mk(input mode_t m, input logic signed [31:0] v);
        in_item_t it;
        it.mode  = m;
        it.value = v;
        return it;
    endfunction

    // an optional clear, then loads and fetches, mostly small values so matches are common
    task automatic add_burst(input int span, input int loads, input int fetches);
        int k;
        if ($urandom_range(0, 5) != 0)
            append_beat(mk(MODE_CLEAR, $urandom));
        for (k = 0; k < loads; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                append_beat(mk(MODE_NONE, $urandom));
            if ($urandom_range(0, 19) == 0)
                append_beat(mk(MODE_LOAD, $urandom));
            else
                append_beat(mk(MODE_LOAD, $urandom_range(0, 2*span) - span));
        end
        for (k = 0; k < fetches; k++)
            append_beat(mk(MODE_FETCH, $urandom));
    endtask

    task automatic wait_quiet();
        while (pending_beats.size() > 0 || in_valid || quad_results.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_target(input logic signed [31:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        target_q = longint'(v);
    endtask

    initial
    begin
        int k;
        int ph;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b1;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        elem_cnt  = 0;
        ovf_flag  = 0;
        target_q  = 0;
        restart_search();
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty fetch, unused mode, all-zero store, extremes
        append_beat(mk(MODE_FETCH, 32'sd0));
        append_beat(mk(MODE_NONE, 32'sh7fffffff));
        for (k = 0; k < 3; k++)
            append_beat(mk(MODE_LOAD, 32'sd0));
        append_beat(mk(MODE_FETCH, 32'sd0));
        append_beat(mk(MODE_LOAD, 32'sd0));
        append_beat(mk(MODE_LOAD, 32'sd0));
        for (k = 0; k < 3; k++)
            append_beat(mk(MODE_FETCH, -1));
        append_beat(mk(MODE_CLEAR, -1));
        append_beat(mk(MODE_LOAD, 32'sh80000000));
        append_beat(mk(MODE_LOAD, 32'sh7fffffff));
        append_beat(mk(MODE_LOAD, 32'sh80000000));
        append_beat(mk(MODE_LOAD, 32'sh7fffffff));
        append_beat(mk(MODE_LOAD, 32'sd1));
        append_beat(mk(MODE_LOAD, -1));
        for (k = 0; k < 4; k++)
            append_beat(mk(MODE_FETCH, 32'sd0));
        wait_quiet();
        write_target(-2);
        for (k = 0; k < 3; k++)
            append_beat(mk(MODE_FETCH, 32'sd0));
        wait_quiet();

        for (ph = 1; ph <= 12; ph++)
        begin
            case (ph % 6)
                0: write_target(32'sh80000000);
                1: write_target(32'sh7fffffff);
                2: write_target(0);
                default: write_target($urandom_range(0, 12) - 6);
            endcase
            calm = (ph % 4 == 3);
            phase_no = ph;
            if (ph == 2)
            begin
                // many fetches so the input backs up behind the held result
                add_burst(2, 10, 25);
            end
            else if (ph == 7)
            begin
                // fill past capacity: dropped loads set the sticky flag
                append_beat(mk(MODE_CLEAR, 0));
                for (k = 0; k < STORE_DEPTH + 3; k++)
                    append_beat(mk(MODE_LOAD, $urandom_range(0, 3)));
                for (k = 0; k < 4; k++)
                    append_beat(mk(MODE_FETCH, $urandom));
            end
            else
            begin
                for (k = 0; k < 5; k++)
                    add_burst($urandom_range(1, 8), $urandom_range(0, 10),
                              $urandom_range(1, 6));
            end
            wait_quiet();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #200000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### four_sum_two_pointer_search_core.f
hdl/fsps_pkg.sv
hdl/fsps_ram.sv
hdl/fsps_ctrl.sv
hdl/fsps_dp.sv
hdl/four_sum_two_pointer_search_core.sv
sim/four_sum_two_pointer_search_core_test.sv
